// ----- design/mmce_pkg.sv -----
// Shared types, algorithm codes, lookup tables and helpers for the checksum engine.
package mmce_pkg;

  localparam logic [3:0] ALG_BSD      = 4'd0;
  localparam logic [3:0] ALG_SYSV     = 4'd1;
  localparam logic [3:0] ALG_SUM8     = 4'd2;
  localparam logic [3:0] ALG_INTERNET = 4'd3;
  localparam logic [3:0] ALG_SUM24    = 4'd4;
  localparam logic [3:0] ALG_SUM32    = 4'd5;
  localparam logic [3:0] ALG_FLETCH4  = 4'd6;
  localparam logic [3:0] ALG_FLETCH8  = 4'd7;
  localparam logic [3:0] ALG_FLETCH16 = 4'd8;
  localparam logic [3:0] ALG_FLETCH32 = 4'd9;
  localparam logic [3:0] ALG_ADLER32  = 4'd10;
  localparam logic [3:0] ALG_XOR8     = 4'd11;
  localparam logic [3:0] ALG_LUHN     = 4'd12;
  localparam logic [3:0] ALG_VERHOEFF = 4'd13;
  localparam logic [3:0] ALG_DAMM     = 4'd14;

  localparam logic [16:0] MOD_ADLER = 17'd65521;
  localparam logic [16:0] MOD_F32   = 17'd65535;

  typedef struct packed {
    logic [31:0]      sum_a;
    logic [15:0]      sum_b;
    logic             pend_valid;
    logic [7:0]       pend_byte;
    logic [3:0][3:0]  luhn;
    logic [7:0][3:0]  vchain;
    logic [2:0]       pos;
  } csum_state_t;

  localparam logic [3:0] VH_D [10][10] = '{
    '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9},
    '{4'd1,4'd2,4'd3,4'd4,4'd0,4'd6,4'd7,4'd8,4'd9,4'd5},
    '{4'd2,4'd3,4'd4,4'd0,4'd1,4'd7,4'd8,4'd9,4'd5,4'd6},
    '{4'd3,4'd4,4'd0,4'd1,4'd2,4'd8,4'd9,4'd5,4'd6,4'd7},
    '{4'd4,4'd0,4'd1,4'd2,4'd3,4'd9,4'd5,4'd6,4'd7,4'd8},
    '{4'd5,4'd9,4'd8,4'd7,4'd6,4'd0,4'd4,4'd3,4'd2,4'd1},
    '{4'd6,4'd5,4'd9,4'd8,4'd7,4'd1,4'd0,4'd4,4'd3,4'd2},
    '{4'd7,4'd6,4'd5,4'd9,4'd8,4'd2,4'd1,4'd0,4'd4,4'd3},
    '{4'd8,4'd7,4'd6,4'd5,4'd9,4'd3,4'd2,4'd1,4'd0,4'd4},
    '{4'd9,4'd8,4'd7,4'd6,4'd5,4'd4,4'd3,4'd2,4'd1,4'd0}};

  localparam logic [3:0] VH_P [8][10] = '{
    '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9},
    '{4'd1,4'd5,4'd7,4'd6,4'd2,4'd8,4'd3,4'd0,4'd9,4'd4},
    '{4'd5,4'd8,4'd0,4'd3,4'd7,4'd9,4'd6,4'd1,4'd4,4'd2},
    '{4'd8,4'd9,4'd1,4'd6,4'd0,4'd4,4'd3,4'd5,4'd2,4'd7},
    '{4'd9,4'd4,4'd5,4'd3,4'd1,4'd2,4'd6,4'd8,4'd7,4'd0},
    '{4'd4,4'd2,4'd8,4'd6,4'd5,4'd7,4'd3,4'd9,4'd0,4'd1},
    '{4'd2,4'd7,4'd9,4'd3,4'd8,4'd0,4'd6,4'd4,4'd1,4'd5},
    '{4'd7,4'd0,4'd4,4'd6,4'd9,4'd1,4'd3,4'd2,4'd5,4'd8}};

  localparam logic [3:0] VH_INV [10] = '{4'd0,4'd4,4'd3,4'd2,4'd1,4'd5,4'd6,4'd7,4'd8,4'd9};

  localparam logic [3:0] DM_T [10][10] = '{
    '{4'd0,4'd3,4'd1,4'd7,4'd5,4'd9,4'd8,4'd6,4'd4,4'd2},
    '{4'd7,4'd0,4'd9,4'd2,4'd1,4'd5,4'd4,4'd8,4'd6,4'd3},
    '{4'd4,4'd2,4'd0,4'd6,4'd8,4'd7,4'd1,4'd3,4'd5,4'd9},
    '{4'd1,4'd7,4'd5,4'd0,4'd9,4'd8,4'd3,4'd4,4'd2,4'd6},
    '{4'd6,4'd1,4'd2,4'd3,4'd0,4'd4,4'd5,4'd9,4'd7,4'd8},
    '{4'd3,4'd6,4'd7,4'd4,4'd2,4'd0,4'd9,4'd5,4'd8,4'd1},
    '{4'd5,4'd8,4'd6,4'd9,4'd7,4'd2,4'd0,4'd1,4'd3,4'd4},
    '{4'd8,4'd9,4'd4,4'd5,4'd3,4'd6,4'd2,4'd0,4'd1,4'd7},
    '{4'd9,4'd4,4'd3,4'd8,4'd6,4'd1,4'd7,4'd2,4'd0,4'd5},
    '{4'd2,4'd5,4'd8,4'd1,4'd4,4'd3,4'd6,4'd7,4'd9,4'd0}};

  function automatic csum_state_t restart_state(input logic [3:0] alg);
    csum_state_t s;
    s = '0;
    s.sum_a = (alg == ALG_ADLER32) ? 32'd1 : 32'd0;
    return s;
  endfunction

endpackage

// ----- design/mmce_if.sv -----
// Valid/ready channel interfaces for message bytes and checksum results.
interface mmce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source(output valid, data_byte, final_byte, input ready);
  modport sink(input valid, data_byte, final_byte, output ready);
endinterface

interface mmce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;
  modport source(output valid, checksum, input ready);
  modport sink(input valid, checksum, output ready);
endinterface

// ----- design/multi_mode_checksum_engine.sv -----
// A byte is registered, then applied; a final byte's checksum goes to the result register.
// Throughput: one byte per cycle except in a stall; input stage and result register overlap.
// A final byte waits in the input stage only while an untaken result is held.
// Reset (synchronous, active high) selects BSD and clears all accumulators.
// A write to the algorithm register restarts the message.
module multi_mode_checksum_engine import mmce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [3:0] cfg_write_data,
  mmce_in_if.sink    in_ch,
  mmce_out_if.source out_ch
);

  logic [3:0]  alg;
  csum_state_t st;
  csum_state_t st_next;
  logic [31:0] res;
  logic        stg_valid;
  logic [7:0]  stg_byte;
  logic        stg_final;
  logic        out_valid;
  logic [31:0] out_sum;
  logic        stall;
  logic        advance;

  mmce_update u_update (
    .alg        (alg),
    .cur        (st),
    .data_byte  (stg_byte),
    .final_byte (stg_final),
    .nxt        (st_next),
    .result     (res)
  );

  // hold a final byte while the previous result is still waiting
  assign stall   = stg_valid && stg_final && out_valid && !out_ch.ready;
  assign advance = stg_valid && !stall;
  assign in_ch.ready = !stall;
  assign out_ch.valid    = out_valid;
  assign out_ch.checksum = out_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      alg       <= ALG_BSD;
      st        <= restart_state(ALG_BSD);
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ch.valid && !stall) begin
        stg_valid <= 1'b1;
        stg_byte  <= in_ch.data_byte;
        stg_final <= in_ch.final_byte;
      end else if (advance) begin
        stg_valid <= 1'b0;
      end
      if (advance && stg_final) begin
        out_valid <= 1'b1;
        out_sum   <= res;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_en) begin
        alg <= cfg_write_data;
        st  <= restart_state(cfg_write_data);
      end else if (advance) begin
        st <= stg_final ? restart_state(alg) : st_next;
      end
    end
  end

endmodule

// ----- design/mmce_update.sv -----
// Per-byte accumulator update and checksum formation for every algorithm.
module mmce_update import mmce_pkg::*; (
  input  logic [3:0]  alg,
  input  csum_state_t cur,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output csum_state_t nxt,
  output logic [31:0] result
);

  logic [15:0] prod;
  logic [3:0]  digit;
  logic        word_ok;
  logic [15:0] word;
  logic [16:0] t17;
  logic [16:0] u17;
  logic [16:0] f17;
  logic [15:0] rot;
  logic [31:0] asum;
  logic [2:0]  a3, b3;
  logic [4:0]  a5, b5;
  logic [8:0]  a9, b9;
  logic [4:0]  lx;
  logic [3:0]  lsel;
  logic [3:0]  lx4;
  logic [2:0]  perm;

  function automatic logic [3:0] add10(input logic [3:0] x, input logic [3:0] y);
    logic [4:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= 5'd10) s = s - 5'd10;
    return s[3:0];
  endfunction

  always_comb begin
    nxt    = cur;
    result = '0;
    prod   = {8'd0, data_byte} * 16'd205;
    digit  = 4'(data_byte - 8'({3'd0, prod[15:11]} * 8'd10));
    // pair bytes into big-endian words, hold a lone leading byte
    word_ok = 1'b1;
    word    = {data_byte, 8'd0};
    if (cur.pend_valid) begin
      word = {cur.pend_byte, data_byte};
      nxt.pend_valid = 1'b0;
      nxt.pend_byte  = '0;
    end else if (!final_byte) begin
      word_ok = 1'b0;
      nxt.pend_valid = 1'b1;
      nxt.pend_byte  = data_byte;
    end
    t17 = '0; u17 = '0; f17 = '0;
    rot = '0; asum = '0;
    a3 = '0; b3 = '0; a5 = '0; b5 = '0; a9 = '0; b9 = '0;
    lx = '0; lsel = '0; lx4 = '0; perm = '0;
    if (alg != ALG_INTERNET && alg != ALG_FLETCH32) begin
      nxt.pend_valid = cur.pend_valid;
      nxt.pend_byte  = cur.pend_byte;
    end
    case (alg)
      ALG_BSD: begin
        rot = {cur.sum_a[0], cur.sum_a[15:1]};
        nxt.sum_a = {16'd0, rot + {8'd0, data_byte}};
        result = nxt.sum_a;
      end
      ALG_SYSV, ALG_SUM8, ALG_SUM24, ALG_SUM32: begin
        asum = cur.sum_a + {24'd0, data_byte};
        nxt.sum_a = asum;
        f17 = {1'b0, asum[15:0]} + {1'b0, asum[31:16]};
        case (alg)
          ALG_SYSV:  result = {16'd0, f17[15:0] + {15'd0, f17[16]}};
          ALG_SUM8:  result = {24'd0, asum[7:0]};
          ALG_SUM24: result = {8'd0, asum[23:0]};
          default:   result = asum;
        endcase
      end
      ALG_INTERNET: begin
        if (word_ok) begin
          t17 = {1'b0, cur.sum_a[15:0]} + {1'b0, word};
          nxt.sum_a = {15'd0, {1'b0, t17[15:0]} + {16'd0, t17[16]}};
        end
        result = {16'd0, ~nxt.sum_a[15:0]};
      end
      ALG_FLETCH4: begin
        a3 = cur.sum_a[2:0];
        b3 = cur.sum_b[2:0];
        for (int i = 3; i >= 0; i--) begin
          a3 = a3 + {1'b0, data_byte[2*i +: 2]};
          if (a3 >= 3'd3) a3 = a3 - 3'd3;
          b3 = b3 + a3;
          if (b3 >= 3'd3) b3 = b3 - 3'd3;
        end
        nxt.sum_a = {29'd0, a3};
        nxt.sum_b = {13'd0, b3};
        result = {28'd0, b3[1:0], a3[1:0]};
      end
      ALG_FLETCH8: begin
        a5 = cur.sum_a[4:0] + {1'b0, data_byte[7:4]};
        if (a5 >= 5'd15) a5 = a5 - 5'd15;
        b5 = cur.sum_b[4:0] + a5;
        if (b5 >= 5'd15) b5 = b5 - 5'd15;
        a5 = a5 + {1'b0, data_byte[3:0]};
        if (a5 >= 5'd15) a5 = a5 - 5'd15;
        b5 = b5 + a5;
        if (b5 >= 5'd15) b5 = b5 - 5'd15;
        nxt.sum_a = {27'd0, a5};
        nxt.sum_b = {11'd0, b5};
        result = {24'd0, b5[3:0], a5[3:0]};
      end
      ALG_FLETCH16: begin
        a9 = cur.sum_a[8:0] + {1'b0, data_byte};
        if (a9 >= 9'd255) a9 = a9 - 9'd255;
        b9 = cur.sum_b[8:0] + a9;
        if (b9 >= 9'd255) b9 = b9 - 9'd255;
        nxt.sum_a = {23'd0, a9};
        nxt.sum_b = {7'd0, b9};
        result = {16'd0, b9[7:0], a9[7:0]};
      end
      ALG_FLETCH32: begin
        if (word_ok) begin
          t17 = {1'b0, cur.sum_a[15:0]} + {1'b0, word};
          if (t17 >= MOD_F32) t17 = t17 - MOD_F32;
          u17 = {1'b0, cur.sum_b} + t17;
          if (u17 >= MOD_F32) u17 = u17 - MOD_F32;
          nxt.sum_a = {16'd0, t17[15:0]};
          nxt.sum_b = u17[15:0];
        end
        result = {nxt.sum_b, nxt.sum_a[15:0]};
      end
      ALG_ADLER32: begin
        t17 = {1'b0, cur.sum_a[15:0]} + {9'd0, data_byte};
        if (t17 >= MOD_ADLER) t17 = t17 - MOD_ADLER;
        u17 = {1'b0, cur.sum_b} + t17;
        if (u17 >= MOD_ADLER) u17 = u17 - MOD_ADLER;
        nxt.sum_a = {16'd0, t17[15:0]};
        nxt.sum_b = u17[15:0];
        result = {u17[15:0], t17[15:0]};
      end
      ALG_XOR8: begin
        nxt.sum_a = {24'd0, cur.sum_a[7:0] ^ data_byte};
        result = nxt.sum_a;
      end
      ALG_LUHN: begin
        lx = {digit, 1'b0};
        if (lx > 5'd9) lx = lx - 5'd9;
        if (!cur.pos[0]) begin
          nxt.luhn[0] = add10(cur.luhn[0], digit);
          nxt.luhn[1] = add10(cur.luhn[1], lx[3:0]);
          lsel = add10(nxt.luhn[1], cur.luhn[2]);
        end else begin
          nxt.luhn[2] = add10(cur.luhn[2], digit);
          nxt.luhn[3] = add10(cur.luhn[3], lx[3:0]);
          lsel = add10(cur.luhn[0], nxt.luhn[3]);
        end
        lx4 = (lsel == 4'd0) ? 4'd0 : 4'd10 - lsel;
        result = {28'd0, lx4};
      end
      ALG_VERHOEFF: begin
        for (int k = 0; k < 8; k++) begin
          perm = 3'(k) - cur.pos;
          nxt.vchain[k] = VH_D[VH_P[perm][digit]][cur.vchain[k]];
        end
        result = {28'd0, VH_INV[nxt.vchain[cur.pos + 3'd1]]};
      end
      ALG_DAMM: begin
        nxt.sum_a = {28'd0, DM_T[cur.sum_a[3:0]][digit]};
        result = nxt.sum_a;
      end
      default: result = '0;
    endcase
    nxt.pos = cur.pos + 3'd1;
  end

endmodule
